// ===== design/pcd_pkg.sv =====
// Shared constants, types and helpers for the pairwise component distance block.
package pcd_pkg;

  localparam int MAX_COMPONENTS = 64;
  localparam int COUNT_GRANULE  = 16;
  localparam int IDX_W          = $clog2(MAX_COMPONENTS);
  localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);
  localparam int CFG_W          = 7;
  localparam int DATA_W         = 32;
  localparam int FRAC_W         = 16;
  localparam int PROD_W         = 2 * DATA_W;
  localparam int SHPROD_W       = PROD_W - FRAC_W;
  localparam int SUM_W          = SHPROD_W + 1;
  localparam int FLAT_W         = 12;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [FLAT_W-1:0]        flat_t;

  localparam q16_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q16_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    q16_t mu;
    q16_t cov;
    q16_t g;
  } comp_t;

  typedef struct packed {
    idx_t  row;
    idx_t  col;
    flat_t flat;
    logic  last;
  } tag_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    idx_t wr_addr;
    logic issue;
    tag_t tag;
  } pcd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic adv;
    logic rd_busy;
  } pcd_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } pcd_state_t;

  function automatic q16_t sat_q16(input logic signed [SUM_W-1:0] v);
    q16_t r;
    if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

endpackage

// ===== design/pcd_if.sv =====
// Valid/ready channel interfaces for component items and distance results.
interface pcd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [pcd_pkg::DATA_W-1:0] mean_value;
  logic signed [pcd_pkg::DATA_W-1:0] covariance_value;
  logic signed [pcd_pkg::DATA_W-1:0] weight_term;

  modport source (output valid, kind, mean_value, covariance_value, weight_term,
                  input ready);
  modport sink   (input valid, kind, mean_value, covariance_value, weight_term,
                  output ready);
endinterface

interface pcd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcd_pkg::DATA_W-1:0] distance;
  logic [pcd_pkg::IDX_W-1:0]         row_index;
  logic [pcd_pkg::IDX_W-1:0]         column_index;
  logic [pcd_pkg::FLAT_W-1:0]        flat_index;
  logic                              last_of_run;

  modport source (output valid, distance, row_index, column_index, flat_index,
                  last_of_run, input ready);
  modport sink   (input valid, distance, row_index, column_index, flat_index,
                  last_of_run, output ready);
endinterface

// ===== design/pcd_ctrl.sv =====
// Controller: set count, item acceptance and pair issue sequencing.
module pcd_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_kind,
  output logic                     in_ready,
  input  logic                     cfg_we,
  input  logic [pcd_pkg::CFG_W-1:0] cfg_wdata,
  input  pcd_pkg::pcd_sts_t        sts,
  output pcd_pkg::pcd_cmd_t        cmd
);
  import pcd_pkg::*;

  pcd_state_t        state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_r;
  cnt_t              seen_r, seen_nxt;
  idx_t              row_r, row_nxt;
  idx_t              col_r, col_nxt;
  flat_t             base_r, base_nxt;
  cnt_t              cnt_min;
  cnt_t              usable;
  logic [2*CNT_W-1:0] tri_prod;
  logic              accept;
  logic              take;
  logic              last_pair;

  always_comb begin
    cnt_min  = (CNT_W'(cfg_r) > CNT_W'(MAX_COMPONENTS)) ? CNT_W'(MAX_COMPONENTS)
                                                        : CNT_W'(cfg_r);
    usable   = CNT_W'((cnt_min / COUNT_GRANULE) * COUNT_GRANULE);
    in_ready = (state_r == ST_IDLE) && !sts.rd_busy;
    accept   = in_valid && in_ready;
    take     = accept && !in_kind && (seen_r < usable);
    tri_prod = (2*CNT_W)'(seen_r) * ((2*CNT_W)'(seen_r) + 1'b1);
    last_pair = (col_r == idx_t'(row_r - 1'b1));

    cmd.load     = take;
    cmd.wr_addr  = seen_r[IDX_W-1:0];
    cmd.issue    = (state_r == ST_RUN) && sts.adv;
    cmd.tag.row  = row_r;
    cmd.tag.col  = col_r;
    cmd.tag.flat = base_r + FLAT_W'(col_r);
    cmd.tag.last = last_pair;
  end

  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    base_nxt  = base_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_kind) begin
          seen_nxt = '0;
        end else if (take) begin
          seen_nxt = seen_r + 1'b1;
          row_nxt  = seen_r[IDX_W-1:0];
          col_nxt  = '0;
          base_nxt = FLAT_W'(tri_prod >> 1);
          // the first component of a set has nothing to pair with
          if (seen_r != '0) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (sts.adv) begin
          if (last_pair) begin
            state_nxt = ST_IDLE;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= '0;
      cfg_r   <= CFG_RESET;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    base_r <= base_nxt;
  end

endmodule

// ===== design/pcd_dp.sv =====
// Datapath: component store, distance pipeline and output register.
module pcd_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  pcd_pkg::pcd_cmd_t cmd,
  input  pcd_pkg::q16_t     in_mean,
  input  pcd_pkg::q16_t     in_cov,
  input  pcd_pkg::q16_t     in_weight,
  output pcd_pkg::pcd_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output pcd_pkg::q16_t     out_distance,
  output pcd_pkg::tag_t     out_tag
);
  import pcd_pkg::*;

  comp_t mem [MAX_COMPONENTS];
  comp_t cur_r;
  comp_t rd_r;
  logic  adv;

  logic  v1_r, v2_r, v3_r, v4_r, vo_r;
  tag_t  tg1_r, tg2_r, tg3_r, tg4_r, tgo_r;

  logic signed [DATA_W:0]   mu_diff, cov_diff, g_diff, g_sum;
  q16_t                     pd_r, cd_r, gd_r, gs2_r;
  logic signed [PROD_W-1:0] pp_r, cg_r;
  q16_t                     gs3_r;
  logic signed [SHPROD_W-1:0] pp_sh, cg_sh, sg_sh;
  q16_t                     sq;
  logic signed [PROD_W-1:0] sg_r;
  logic signed [SHPROD_W-1:0] t1_r;
  q16_t                     dist_r;

  assign adv = !vo_r || out_ready;
  assign sts.adv     = adv;
  assign sts.rd_busy = v1_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[cmd.wr_addr] <= '{mu: in_mean, cov: in_cov, g: in_weight};
      cur_r            <= '{mu: in_mean, cov: in_cov, g: in_weight};
    end
    if (adv) begin
      rd_r <= mem[cmd.tag.col];
    end
  end

  always_comb begin
    mu_diff  = {cur_r.mu[DATA_W-1], cur_r.mu} - {rd_r.mu[DATA_W-1], rd_r.mu};
    cov_diff = {cur_r.cov[DATA_W-1], cur_r.cov} - {rd_r.cov[DATA_W-1], rd_r.cov};
    g_diff   = {rd_r.g[DATA_W-1], rd_r.g} - {cur_r.g[DATA_W-1], cur_r.g};
    g_sum    = {cur_r.g[DATA_W-1], cur_r.g} + {rd_r.g[DATA_W-1], rd_r.g};
    pp_sh    = pp_r[PROD_W-1:FRAC_W];
    cg_sh    = cg_r[PROD_W-1:FRAC_W];
    sg_sh    = sg_r[PROD_W-1:FRAC_W];
    sq       = sat_q16(SUM_W'(pp_sh));
  end

  // payload stages advance together with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      tg1_r  <= cmd.tag;
      pd_r   <= sat_q16(SUM_W'(mu_diff));
      cd_r   <= sat_q16(SUM_W'(cov_diff));
      gd_r   <= sat_q16(SUM_W'(g_diff));
      gs2_r  <= sat_q16(SUM_W'(g_sum));
      tg2_r  <= tg1_r;
      pp_r   <= pd_r * pd_r;
      cg_r   <= cd_r * gd_r;
      gs3_r  <= gs2_r;
      tg3_r  <= tg2_r;
      sg_r   <= sq * gs3_r;
      t1_r   <= cg_sh;
      tg4_r  <= tg3_r;
      dist_r <= sat_q16(SUM_W'(t1_r) + SUM_W'(sg_sh));
      tgo_r  <= tg4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  assign out_valid    = vo_r;
  assign out_distance = dist_r;
  assign out_tag      = tgo_r;

endmodule

// ===== design/pairwise_component_distance.sv =====
// Top level of the pairwise component distance block.
// Component items enter on in_chan; a restart item (kind 1) clears the set and a
// component beyond the usable count (component_count capped at 64, rounded down
// to a multiple of 16) is dropped. Component i of a set is paired with every
// earlier component j in order j = 0..i-1, one pair issued per cycle while out_chan
// does not stall, from the single read port of the component store, and each pair
// leaves on out_chan after the distance pipeline. A component with index i > 0
// holds in_chan.ready low while its pairs are issued, so the next item waits until
// they are; restarts, dropped items and the first component of a set do not hold
// it low. Stalls on out_chan hold the whole pipeline.
// component_count is written through cfg_we / cfg_wdata.
module pairwise_component_distance (
  input  logic                      clk,
  input  logic                      rst_n,
  pcd_in_if.sink                    in_chan,
  pcd_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [pcd_pkg::CFG_W-1:0] cfg_wdata
);
  import pcd_pkg::*;

  pcd_cmd_t cmd;
  pcd_sts_t sts;
  tag_t     out_tag;

  pcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_kind   (in_chan.kind),
    .in_ready  (in_chan.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_mean      (in_chan.mean_value),
    .in_cov       (in_chan.covariance_value),
    .in_weight    (in_chan.weight_term),
    .sts          (sts),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_distance (out_chan.distance),
    .out_tag      (out_tag)
  );

  assign out_chan.row_index    = out_tag.row;
  assign out_chan.column_index = out_tag.col;
  assign out_chan.flat_index   = out_tag.flat;
  assign out_chan.last_of_run  = out_tag.last;

endmodule

// ===== design/pcd_chk.sv =====
// Port-level checker for the pairwise component distance block, with its bind.
module pcd_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pcd_pkg::DATA_W-1:0] distance,
  input logic [pcd_pkg::IDX_W-1:0]  row_index,
  input logic [pcd_pkg::IDX_W-1:0]  column_index,
  input logic [pcd_pkg::FLAT_W-1:0] flat_index,
  input logic                       last_of_run
);
  import pcd_pkg::*;

  logic [2*IDX_W+1:0] tri_prod;
  flat_t              flat_exp;

  assign tri_prod = (2*IDX_W+2)'(row_index) * ((2*IDX_W+2)'(row_index) + 1'b1);
  assign flat_exp = FLAT_W'(tri_prod >> 1) + FLAT_W'(column_index);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(flat_index))
    else $error("result item changed while stalled");

  a_col_below_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> column_index < row_index)
    else $error("column index not below row index");

  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> flat_index == flat_exp)
    else $error("flat index does not match row and column");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> last_of_run == (IDX_W'(column_index + 1'b1) == row_index))
    else $error("last flag not on the final pair of the run");

endmodule

bind pairwise_component_distance pcd_chk u_pcd_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .distance     (out_chan.distance),
  .row_index    (out_chan.row_index),
  .column_index (out_chan.column_index),
  .flat_index   (out_chan.flat_index),
  .last_of_run  (out_chan.last_of_run)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the pairwise component distance block.
module tb_top;
  import pcd_pkg::*;

  localparam logic KIND_COMPONENT = 1'b0;
  localparam logic KIND_RESTART   = 1'b1;
  localparam int   STALL_LIMIT    = 4000;
  localparam int   LONG_HOLD      = 400;
  localparam int   MAX_REPORTS    = 40;

  typedef struct packed {
    logic kind;
    q16_t mu;
    q16_t cov;
    q16_t g;
  } comp_item_t;

  typedef struct packed {
    q16_t  distance;
    idx_t  row;
    idx_t  col;
    flat_t flat;
    logic  last;
  } pair_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  pcd_in_if  in_chan();
  pcd_out_if out_chan();

  pairwise_component_distance u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  comp_item_t   comp_pending[$];
  pair_result_t pair_results_due[$];

  // Shadow copy of the component set and the count register
  q16_t mean_hist[MAX_COMPONENTS];
  q16_t cov_hist[MAX_COMPONENTS];
  q16_t weight_hist[MAX_COMPONENTS];
  int   set_fill     = 0;
  int   count_reg    = CFG_RESET;

  int   mismatches   = 0;
  int   results_seen = 0;
  int   idle_cycles  = 0;
  bit   in_fire      = 0;
  int   burst_left   = 1;
  int   gap_left     = 0;
  int   hold_left    = 0;
  int   holds_done   = 0;
  int   stall_mode   = 0;
  int   mode_left    = 0;

  function automatic logic signed [63:0] clamp_q16(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic q16_t pair_distance(input q16_t mu_i, input q16_t cov_i,
                                         input q16_t g_i, input q16_t mu_j,
                                         input q16_t cov_j, input q16_t g_j);
    logic signed [63:0] mi, mj, ci, cj, gi, gj;
    logic signed [63:0] pd, cd, gd, gs, t1, sq, t2, d;
    mi = mu_i;
    mj = mu_j;
    ci = cov_i;
    cj = cov_j;
    gi = g_i;
    gj = g_j;
    pd = clamp_q16(mi - mj);
    cd = clamp_q16(ci - cj);
    gd = clamp_q16(gj - gi);
    gs = clamp_q16(gi + gj);
    // arithmetic shift of a signed product truncates toward minus infinity
    t1 = (cd * gd) >>> FRAC_W;
    sq = clamp_q16((pd * pd) >>> FRAC_W);
    t2 = (sq * gs) >>> FRAC_W;
    d  = clamp_q16(t1 + t2);
    return d[DATA_W-1:0];
  endfunction

  function automatic int usable_count(input int cnt);
    int c;
    c = (cnt > MAX_COMPONENTS) ? MAX_COMPONENTS : cnt;
    return c - (c % COUNT_GRANULE);
  endfunction

  function automatic q16_t random_q16();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return '1;
      4, 5: return q16_t'($urandom_range(0, 32'h3ffff)) - q16_t'(32'h20000);
      default: return q16_t'($urandom);
    endcase
  endfunction

  // Update the shadow set for one accepted item and queue the pairs it causes
  task automatic record_component(input comp_item_t it);
    pair_result_t r;
    int i;
    if (it.kind == KIND_RESTART) begin
      set_fill = 0;
      return;
    end
    i = set_fill;
    if (i >= usable_count(count_reg) || i >= MAX_COMPONENTS) begin
      return;
    end
    for (int j = 0; j < i; j++) begin
      r.distance = pair_distance(it.mu, it.cov, it.g,
                                 mean_hist[j], cov_hist[j], weight_hist[j]);
      r.row      = idx_t'(i);
      r.col      = idx_t'(j);
      r.flat     = flat_t'(i * (i + 1) / 2 + j);
      r.last     = (j == i - 1);
      pair_results_due.push_back(r);
    end
    mean_hist[i]   = it.mu;
    cov_hist[i]    = it.cov;
    weight_hist[i] = it.g;
    set_fill       = i + 1;
  endtask

  task automatic push_component(input q16_t mu, input q16_t cov, input q16_t g);
    comp_pending.push_back('{KIND_COMPONENT, mu, cov, g});
  endtask

  task automatic push_restart();
    comp_pending.push_back('{KIND_RESTART, random_q16(), random_q16(), random_q16()});
  endtask

  task automatic wait_until_idle();
    while (comp_pending.size() != 0 || pair_results_due.size() != 0) begin
      @(posedge clk);
    end
    // let dropped items and restarts finish inside the block
    repeat (16) @(posedge clk);
  endtask

  task automatic set_component_count(input int value);
    wait_until_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stimulus
  initial begin
    int usable;
    int budget;
    int n;
    int k;
    int phase_counts[10];

    phase_counts             = '{64, 17, 63, 0, 33, 64, 31, 48, 16, 64};
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_wdata                = '0;
    in_chan.valid            = 1'b0;
    in_chan.kind             = KIND_COMPONENT;
    in_chan.mean_value       = '0;
    in_chan.covariance_value = '0;
    in_chan.weight_term      = '0;
    out_chan.ready           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a full set of sixteen with extreme values, overflow, restart
    set_component_count(16);
    push_restart();
    push_component(Q_MAX, Q_MIN, Q_MAX);
    push_component(Q_MIN, Q_MAX, Q_MIN);
    push_component('0, '0, '0);
    push_component('1, '1, '1);
    push_component(q16_t'(32'h10000), q16_t'(32'h20000), q16_t'(32'h8000));
    for (int r = 0; r < 10; r++) begin
      push_component(random_q16(), random_q16(), random_q16());
    end
    push_component(Q_MAX, Q_MAX, Q_MAX);
    push_component(Q_MIN, Q_MIN, Q_MIN);
    push_restart();
    push_component(q16_t'(32'h30000), q16_t'(32'h18000), q16_t'(32'h4000));
    push_component(q16_t'(-32'sh30000), q16_t'(32'h8000), q16_t'(32'h2000));
    // Raise the count within a set: accepted components stay
    set_component_count(48);
    push_component(random_q16(), random_q16(), random_q16());
    set_component_count(0);
    push_component(random_q16(), random_q16(), random_q16());
    push_restart();

    // Random: sets of random size and content, some noise
    foreach (phase_counts[p]) begin
      set_component_count(phase_counts[p]);
      usable = usable_count(phase_counts[p]);
      budget = (usable == 0) ? 8 : 36;
      n      = 0;
      while (n < budget) begin
        if ($urandom_range(0, 9) < 7) begin
          k = $urandom_range(2, usable + 2);
          push_restart();
          repeat (k) push_component(random_q16(), random_q16(), random_q16());
          n += k + 1;
        end else begin
          if ($urandom_range(0, 1) == 1) begin
            push_restart();
          end else begin
            push_component(random_q16(), random_q16(), random_q16());
          end
          n++;
        end
      end
    end

    wait_until_idle();
    if (mismatches == 0 && pair_results_due.size() == 0) begin
      $display("pairwise_component_distance test passed");
    end else begin
      $display("pairwise_component_distance test failed");
    end
    $finish;
  end

  // Driver: bursts of items with random gaps, hold an item until taken
  always @(negedge clk) begin
    if (rst_n && !(in_chan.valid && !in_fire)) begin
      if (gap_left > 0) begin
        in_chan.valid <= 1'b0;
        gap_left--;
      end else if (comp_pending.size() != 0) begin
        in_chan.valid            <= 1'b1;
        in_chan.kind             <= comp_pending[0].kind;
        in_chan.mean_value       <= comp_pending[0].mu;
        in_chan.covariance_value <= comp_pending[0].cov;
        in_chan.weight_term      <= comp_pending[0].g;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that changes over time, plus long hold-offs
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (holds_done < 2 && results_seen >= 300 + holds_done * 2500) begin
        out_chan.ready <= 1'b0;
        hold_left = LONG_HOLD - 1;
        holds_done++;
      end else begin
        if (mode_left <= 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 200);
        end
        mode_left--;
        case (stall_mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= ($urandom_range(0, 3) != 0);
          2: out_chan.ready <= ($urandom_range(0, 1) == 1);
          default: out_chan.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Monitor: track accepted items and register writes, check each result
  always @(posedge clk) begin
    pair_result_t got;
    pair_result_t want;
    if (!rst_n) begin
      set_fill  = 0;
      count_reg = CFG_RESET;
      in_fire   = 1'b0;
    end else begin
      if (cfg_we) begin
        count_reg = cfg_wdata;
      end
      in_fire = (in_chan.valid === 1'b1) && (in_chan.ready === 1'b1);
      if (in_fire) begin
        record_component(comp_pending.pop_front());
      end
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        results_seen++;
        got = {out_chan.distance, out_chan.row_index, out_chan.column_index,
               out_chan.flat_index, out_chan.last_of_run};
        if (pair_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: unexpected pair: distance=%h row=%0d col=%0d flat=%0d last=%0b",
                     $time, got.distance, got.row, got.col, got.flat, got.last);
          end
        end else begin
          want = pair_results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: pair mismatch: expected distance=%h row=%0d col=%0d flat=%0d last=%0b",
                       $time, want.distance, want.row, want.col, want.flat, want.last);
              $display("%0t:                actual   distance=%h row=%0d col=%0d flat=%0d last=%0b",
                       $time, got.distance, got.row, got.col, got.flat, got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("pairwise_component_distance test failed");
      $finish;
    end
  end

endmodule
